// File: design/phe_pkg.sv
// Shared types, constants and table functions for the probe hybridization energy block.
`default_nettype none
package phe_pkg;

    localparam int PHE_PROBE_LEN   = 25;
    localparam int PHE_CLASSES     = 16;
    localparam int PHE_MM_BASE     = 12;
    localparam int PHE_WEIGHT_A    = 11;
    localparam int PHE_WEIGHT_B    = 12;
    localparam int PHE_QUEUE_DEPTH = 2;

    localparam int CLASS_W = 4;
    localparam int CNT_W   = 5;
    localparam int WGT_W   = 11;
    localparam int EN_W    = 14;
    localparam int ACC_W   = 16;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PEN_W   = 9;
    localparam int INIT_W  = 12;
    localparam int TERM_W  = 10;
    localparam int TBL_W   = 9;
    localparam int SUMW_W  = 13;
    localparam int KIDX_W  = 6;

    localparam logic signed [CFG_W-1:0] DNA_START_RST = -11'sd310;
    localparam logic signed [CFG_W-1:0] RNA_START_RST = -11'sd409;
    localparam logic signed [PEN_W-1:0] TERM_AT_RST   = -9'sd45;

    localparam logic [WGT_W-1:0]  WGT_MAX  = '1;
    localparam logic [SUMW_W-1:0] WGT_LIM  = SUMW_W'(2047);
    localparam logic signed [ACC_W-1:0] EN_MAX = 16'sd8191;
    localparam logic signed [ACC_W-1:0] EN_MIN = -16'sd8192;

    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DNA_START = 2'd0,
        CFG_RNA_START = 2'd1,
        CFG_TERM_AT   = 2'd2
    } phe_cfg_idx_t;

    typedef enum logic [1:0] {
        ACC_IDLE,
        ACC_RUN,
        ACC_DONE
    } phe_acc_state_t;

    typedef struct packed {
        logic [PHE_CLASSES-1:0][CNT_W-1:0] count;
        logic [PHE_CLASSES-1:0][WGT_W-1:0] weight;
        logic signed [EN_W-1:0]            dr;
        logic signed [EN_W-1:0]            rr;
    } phe_res_t;

    function automatic logic [TBL_W-1:0] dna_tbl(input logic [CLASS_W-1:0] c);
        logic [TBL_W-1:0] v;
        case (c)
            4'd0:    v = 9'd290;
            4'd1:    v = 9'd270;
            4'd2:    v = 9'd110;
            4'd3:    v = 9'd130;
            4'd4:    v = 9'd170;
            4'd5:    v = 9'd210;
            4'd6:    v = 9'd90;
            4'd7:    v = 9'd90;
            4'd8:    v = 9'd160;
            4'd9:    v = 9'd150;
            4'd10:   v = 9'd20;
            4'd11:   v = 9'd60;
            4'd12:   v = 9'd180;
            4'd13:   v = 9'd210;
            4'd14:   v = 9'd90;
            default: v = 9'd100;
        endcase
        return v;
    endfunction

    function automatic logic [TBL_W-1:0] rna_tbl(input logic [CLASS_W-1:0] c);
        logic [TBL_W-1:0] v;
        case (c)
            4'd0:    v = 9'd326;
            4'd1:    v = 9'd342;
            4'd2:    v = 9'd224;
            4'd3:    v = 9'd235;
            4'd4:    v = 9'd236;
            4'd5:    v = 9'd326;
            4'd6:    v = 9'd208;
            4'd7:    v = 9'd211;
            4'd8:    v = 9'd211;
            4'd9:    v = 9'd235;
            4'd10:   v = 9'd93;
            4'd11:   v = 9'd133;
            4'd12:   v = 9'd208;
            4'd13:   v = 9'd224;
            4'd14:   v = 9'd110;
            default: v = 9'd93;
        endcase
        return v;
    endfunction

    function automatic logic [TERM_W-1:0] pair_wgt(input logic [KIDX_W-1:0] k);
        logic signed [KIDX_W:0]     a;
        logic signed [KIDX_W:0]     b;
        logic signed [2*KIDX_W+1:0] p;
        a = $signed({1'b0, k}) - 7'sd11;
        b = $signed({1'b0, k}) - 7'sd12;
        p = (2*KIDX_W+2)'(a) * (2*KIDX_W+2)'(b);
        return p[TERM_W-1:0];
    endfunction

    function automatic logic signed [EN_W-1:0] sat_energy(input logic signed [ACC_W-1:0] v);
        logic signed [EN_W-1:0] r;
        if (v > EN_MAX) begin
            r = EN_MAX[EN_W-1:0];
        end else if (v < EN_MIN) begin
            r = EN_MIN[EN_W-1:0];
        end else begin
            r = v[EN_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/probe_hybridization_energy.sv
// Results: sixteen words per accepted probe, one word a cycle while m_tready is high.
// The sixteen-word output serializer limits the probe rate; the pair walk overlaps the serializer.
// A two-entry queue and a result holding register let intake continue while output stalls, until the queue is full.
// Reset (aresetn low, synchronous) empties the queue, idles all control and restores the
//   three configuration registers to their defaults.
`default_nettype none
module probe_hybridization_energy
    import phe_pkg::*;
#(
    parameter int PROBE_LEN = PHE_PROBE_LEN
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // probe_bases
    input  wire logic [((2*PROBE_LEN+7)/8)*8-1:0] s_tdata,
    // column_odd, parity_reversed, annotated
    input  wire logic [2:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pair_class, pair_count, pair_weight, dna_rna_energy, rna_rna_energy
    output logic [47:0]                 m_tdata,
    output logic                        m_tlast
);

    localparam int BW = 2 * PROBE_LEN;
    localparam int JW = BW + CFG_W + INIT_W + 1;

    logic [BW-1:0]              f_bases;
    logic signed [CFG_W-1:0]    f_dr_init;
    logic signed [INIT_W-1:0]   f_rr_init;
    logic                       f_ann;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    logic [JW-1:0]              q_data;
    logic                       r_valid;
    logic                       r_take;
    phe_res_t                   r_data;

    assign s_tready = !q_full;

    phe_front #(
        .PROBE_LEN (PROBE_LEN)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_bases           (s_tdata[BW-1:0]),
        .in_column_odd      (s_tuser[0]),
        .in_parity_reversed (s_tuser[1]),
        .in_annotated       (s_tuser[2]),
        .job_bases          (f_bases),
        .job_dr_init        (f_dr_init),
        .job_rr_init        (f_rr_init),
        .job_ann            (f_ann)
    );

    phe_fifo #(
        .WIDTH (JW),
        .DEPTH (PHE_QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data ({f_ann, f_rr_init, f_dr_init, f_bases}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    phe_accum #(
        .PROBE_LEN (PROBE_LEN)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (!q_empty),
        .job_bases   (q_data[BW-1:0]),
        .job_dr_init (q_data[BW+CFG_W-1:BW]),
        .job_rr_init (q_data[BW+CFG_W+INIT_W-1:BW+CFG_W]),
        .job_ann     (q_data[JW-1]),
        .job_pop     (q_pop),
        .res_valid   (r_valid),
        .res_take    (r_take),
        .res         (r_data)
    );

    phe_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (r_valid),
        .res_take  (r_take),
        .res       (r_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// File: design/phe_front.sv
// Input classifier: configuration registers, mismatch complement and start energies.
`default_nettype none
module phe_front
    import phe_pkg::*;
#(
    parameter int PROBE_LEN = PHE_PROBE_LEN
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    input  wire logic [2*PROBE_LEN-1:0]   in_bases,
    input  wire logic                     in_column_odd,
    input  wire logic                     in_parity_reversed,
    input  wire logic                     in_annotated,
    output logic [2*PROBE_LEN-1:0]        job_bases,
    output logic signed [CFG_W-1:0]       job_dr_init,
    output logic signed [INIT_W-1:0]      job_rr_init,
    output logic                          job_ann
);

    localparam int BW = 2 * PROBE_LEN;
    localparam logic [BW-1:0] MM_MASK = (PROBE_LEN > PHE_MM_BASE) ?
                                        (BW'(1) << (2 * PHE_MM_BASE)) : '0;

    logic signed [CFG_W-1:0] dna_start_reg;
    logic signed [CFG_W-1:0] rna_start_reg;
    logic signed [PEN_W-1:0] term_at_reg;

    logic                     pm;
    logic [1:0]               first_base;
    logic [1:0]               last_base;
    logic signed [INIT_W-1:0] pen_ext;
    logic signed [INIT_W-1:0] pen_first;
    logic signed [INIT_W-1:0] pen_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dna_start_reg <= DNA_START_RST;
            rna_start_reg <= RNA_START_RST;
            term_at_reg   <= TERM_AT_RST;
        end else if (cfg_wr_en) begin
            case (phe_cfg_idx_t'(cfg_index))
                CFG_DNA_START: dna_start_reg <= cfg_wdata;
                CFG_RNA_START: rna_start_reg <= cfg_wdata;
                CFG_TERM_AT:   term_at_reg   <= cfg_wdata[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pm         = in_column_odd ^ in_parity_reversed;
        job_bases  = pm ? in_bases : (in_bases ^ MM_MASK);
        first_base = job_bases[1:0];
        last_base  = job_bases[BW-1 -: 2];
        pen_ext    = {{(INIT_W-PEN_W){term_at_reg[PEN_W-1]}}, term_at_reg};
        pen_first  = (first_base == BASE_A) ? pen_ext : '0;
        pen_last   = (last_base == BASE_T) ? pen_ext : '0;
        job_dr_init = pm ? dna_start_reg : '0;
        job_rr_init = {{(INIT_W-CFG_W){rna_start_reg[CFG_W-1]}}, rna_start_reg}
                      + pen_first + pen_last;
        job_ann    = in_annotated;
    end

endmodule
`default_nettype wire

// File: design/phe_fifo.sv
// Short job queue between the classifier and the pair accumulator.
`default_nettype none
module phe_fifo
    import phe_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = PHE_QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// File: design/phe_accum.sv
// Pair accumulator: walks two base pairs a cycle, builds per-class counts, weights and energies.
`default_nettype none
module phe_accum
    import phe_pkg::*;
#(
    parameter int PROBE_LEN = PHE_PROBE_LEN
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   job_valid,
    input  wire logic [2*PROBE_LEN-1:0] job_bases,
    input  wire logic signed [CFG_W-1:0]  job_dr_init,
    input  wire logic signed [INIT_W-1:0] job_rr_init,
    input  wire logic                   job_ann,
    output logic                        job_pop,
    output logic                        res_valid,
    input  wire logic                   res_take,
    output phe_res_t                    res
);

    localparam int BW = 2 * PROBE_LEN;
    localparam int KW = $clog2(PROBE_LEN);

    phe_acc_state_t state_reg, state_next;

    logic [BW-1:0]               sh_reg;
    logic [KW-1:0]               k_reg;
    logic                        ann_reg;
    logic signed [ACC_W-1:0]     dr_reg;
    logic signed [ACC_W-1:0]     rr_reg;
    logic [PHE_CLASSES-1:0][CNT_W-1:0] cnt_reg;
    logic [PHE_CLASSES-1:0][WGT_W-1:0] wgt_reg;

    logic                        start;
    logic                        step;
    logic                        last_step;
    logic                        v1;
    logic [CLASS_W-1:0]          c0;
    logic [CLASS_W-1:0]          c1;
    logic [TERM_W-1:0]           w0;
    logic [TERM_W-1:0]           w1;
    logic [PHE_CLASSES-1:0][CNT_W-1:0] cnt_next;
    logic [PHE_CLASSES-1:0][WGT_W-1:0] wgt_next;
    logic [SUMW_W-1:0]           wsum [PHE_CLASSES];
    logic signed [ACC_W-1:0]     dr_next;
    logic signed [ACC_W-1:0]     rr_next;

    always_comb begin
        last_step = (({1'b0, k_reg} + (KW+1)'(2)) >= (KW+1)'(PROBE_LEN - 1));
        v1        = (({1'b0, k_reg} + (KW+1)'(1)) < (KW+1)'(PROBE_LEN - 1));
        c0        = {sh_reg[3:2], sh_reg[1:0]};
        c1        = {sh_reg[5:4], sh_reg[3:2]};
        w0        = pair_wgt(KIDX_W'(k_reg));
        w1        = pair_wgt(KIDX_W'(k_reg) + KIDX_W'(1));
        for (int n = 0; n < PHE_CLASSES; n++) begin
            cnt_next[n] = cnt_reg[n]
                          + CNT_W'(c0 == CLASS_W'(n))
                          + CNT_W'(v1 && (c1 == CLASS_W'(n)));
            wsum[n]     = SUMW_W'(wgt_reg[n])
                          + ((c0 == CLASS_W'(n)) ? SUMW_W'(w0) : '0)
                          + ((v1 && (c1 == CLASS_W'(n))) ? SUMW_W'(w1) : '0);
            wgt_next[n] = (wsum[n] > WGT_LIM) ? WGT_MAX : wsum[n][WGT_W-1:0];
        end
        dr_next = dr_reg + $signed(ACC_W'(dna_tbl(c0)))
                  + (v1 ? $signed(ACC_W'(dna_tbl(c1))) : '0);
        rr_next = rr_reg + $signed(ACC_W'(rna_tbl(c0)))
                  + (v1 ? $signed(ACC_W'(rna_tbl(c1))) : '0);
    end

    always_comb begin
        state_next = state_reg;
        start      = 1'b0;
        step       = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ACC_IDLE: begin
                if (job_valid) begin
                    start      = 1'b1;
                    state_next = ACC_RUN;
                end
            end
            ACC_RUN: begin
                step = 1'b1;
                if (last_step) begin
                    state_next = ACC_DONE;
                end
            end
            ACC_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    if (job_valid) begin
                        start      = 1'b1;
                        state_next = ACC_RUN;
                    end else begin
                        state_next = ACC_IDLE;
                    end
                end
            end
            default: state_next = ACC_IDLE;
        endcase
        job_pop = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ACC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= job_bases;
            k_reg   <= '0;
            ann_reg <= job_ann;
            dr_reg  <= ACC_W'(job_dr_init);
            rr_reg  <= ACC_W'(job_rr_init);
            cnt_reg <= '0;
            wgt_reg <= '0;
        end else if (step) begin
            sh_reg  <= sh_reg >> 4;
            k_reg   <= k_reg + KW'(2);
            dr_reg  <= dr_next;
            rr_reg  <= rr_next;
            cnt_reg <= cnt_next;
            wgt_reg <= wgt_next;
        end
    end

    always_comb begin
        if (ann_reg) begin
            res.count  = cnt_reg;
            res.weight = wgt_reg;
            res.dr     = sat_energy(dr_reg);
            res.rr     = sat_energy(rr_reg);
        end else begin
            res = '0;
        end
    end

`ifndef SYNTHESIS
    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ACC_RUN) |-> ({1'b0, k_reg} < (KW+1)'(PROBE_LEN - 1)))
        else $error("pair index past probe end");
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ACC_RUN && last_step) |=> (state_reg == ACC_DONE))
        else $error("walk did not finish after last step");
`endif

endmodule
`default_nettype wire

// File: design/phe_emit.sv
// Result serializer: holds one finished probe and sends its sixteen class words.
`default_nettype none
module phe_emit
    import phe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        res_valid,
    output logic             res_take,
    input  wire phe_res_t    res,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    output logic             m_tlast
);

    phe_res_t             buf_reg;
    logic                 busy_reg;
    logic [CLASS_W-1:0]   idx_reg;
    logic                 out_acc;
    logic                 last_acc;

    always_comb begin
        m_tvalid = busy_reg;
        m_tlast  = (idx_reg == CLASS_W'(PHE_CLASSES - 1));
        m_tdata  = {buf_reg.rr, buf_reg.dr, buf_reg.weight[idx_reg],
                    buf_reg.count[idx_reg], idx_reg};
        out_acc  = m_tvalid && m_tready;
        last_acc = out_acc && m_tlast;
        res_take = res_valid && (!busy_reg || last_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (res_take) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (out_acc) begin
            if (m_tlast) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + CLASS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            buf_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_idx_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && !m_tlast) |=> (idx_reg == $past(idx_reg) + CLASS_W'(1)))
        else $error("class index did not advance");
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_acc && !res_valid) |=> !m_tvalid)
        else $error("output still valid after last word");
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |=> (m_tvalid && idx_reg == '0))
        else $error("new probe did not start at class zero");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the probe hybridization energy block.
`timescale 1ns / 1ps
module tb;
    import phe_pkg::*;

    localparam int WEIGHT_CEIL = 2047;
    localparam int ENERGY_HI   = 8191;
    localparam int ENERGY_LO   = -8192;
    localparam int SINK_HOLD   = 400;
    localparam int RANDOM_RUN  = 66;

    localparam logic [15:0][8:0] DR_NN = {
        9'd100, 9'd90, 9'd210, 9'd180, 9'd60, 9'd20, 9'd150, 9'd160,
        9'd90, 9'd90, 9'd210, 9'd170, 9'd130, 9'd110, 9'd270, 9'd290
    };
    localparam logic [15:0][8:0] RR_NN = {
        9'd93, 9'd110, 9'd224, 9'd208, 9'd133, 9'd93, 9'd235, 9'd211,
        9'd211, 9'd208, 9'd326, 9'd236, 9'd235, 9'd224, 9'd342, 9'd326
    };

    typedef struct {
        logic [3:0]         cls;
        logic [4:0]         cnt;
        logic [10:0]        wgt;
        logic signed [13:0] dr;
        logic signed [13:0] rr;
        logic               last;
    } energy_word_t;

    typedef enum {ROW_MODEL, ROW_UNIFORM, ROW_BLANK} row_kind_t;

    typedef struct {
        logic [49:0] bases;
        logic        col;
        logic        par;
        logic        ann;
        row_kind_t   kind;
        logic [3:0]  cls;
        int          dr;
        int          rr;
    } probe_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DNA_START;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [55:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [47:0]          m_tdata;
    logic                 m_tlast;

    logic signed [10:0]   dr_start = DNA_START_RST;
    logic signed [10:0]   rr_start = RNA_START_RST;
    logic signed [8:0]    at_pen   = TERM_AT_RST;

    energy_word_t         pending_words [$];
    energy_word_t         want_word;
    probe_row_t           directed [$];
    int                   error_count = 0;
    bit                   idle_on = 1'b1;
    bit                   hold_sink = 1'b0;

    probe_hybridization_energy dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("probe_hybridization_energy verification failed");
        $finish;
    end

    function automatic logic signed [13:0] clamp_energy(input int v);
        if (v > ENERGY_HI) begin
            return 14'(ENERGY_HI);
        end else if (v < ENERGY_LO) begin
            return 14'(ENERGY_LO);
        end
        return 14'(v);
    endfunction

    function automatic void predict_probe(input logic [49:0] bases, input logic col,
                                          input logic par, input logic ann);
        logic [1:0]   seq [PHE_PROBE_LEN];
        int           cnt [PHE_CLASSES];
        int           wgt [PHE_CLASSES];
        int           dr;
        int           rr;
        int           w;
        int           k;
        int           n;
        logic [3:0]   c;
        energy_word_t e;
        dr = 0;
        rr = 0;
        for (n = 0; n < PHE_CLASSES; n++) begin
            cnt[n] = 0;
            wgt[n] = 0;
        end
        if (ann) begin
            for (k = 0; k < PHE_PROBE_LEN; k++) begin
                seq[k] = bases[2*k +: 2];
            end
            if (!(col ^ par)) begin
                seq[PHE_MM_BASE] ^= 2'b01;
            end
            if (col ^ par) begin
                dr = int'(dr_start);
            end
            rr = int'(rr_start);
            if (seq[0] == BASE_A) begin
                rr += int'(at_pen);
            end
            if (seq[PHE_PROBE_LEN-1] == BASE_T) begin
                rr += int'(at_pen);
            end
            for (k = 0; k < PHE_PROBE_LEN - 1; k++) begin
                c = {seq[k+1], seq[k]};
                w = (k - PHE_WEIGHT_A) * (k - PHE_WEIGHT_B);
                cnt[c]++;
                if (w > 0) begin
                    wgt[c] += w;
                end
                if (wgt[c] > WEIGHT_CEIL) begin
                    wgt[c] = WEIGHT_CEIL;
                end
                dr += int'(DR_NN[c]);
                rr += int'(RR_NN[c]);
            end
        end
        for (n = 0; n < PHE_CLASSES; n++) begin
            e.cls  = 4'(n);
            e.cnt  = 5'(cnt[n]);
            e.wgt  = 11'(wgt[n]);
            e.dr   = clamp_energy(dr);
            e.rr   = clamp_energy(rr);
            e.last = (n == PHE_CLASSES - 1);
            pending_words.push_back(e);
        end
    endfunction

    task automatic flag_error(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                flag_error("word with nothing pending, class", int'(m_tdata[3:0]), -1);
            end else begin
                want_word = pending_words.pop_front();
                if (m_tdata[3:0] != want_word.cls)
                    flag_error("pair_class", int'(m_tdata[3:0]), int'(want_word.cls));
                if (m_tdata[8:4] != want_word.cnt)
                    flag_error("pair_count", int'(m_tdata[8:4]), int'(want_word.cnt));
                if (m_tdata[19:9] != want_word.wgt)
                    flag_error("pair_weight", int'(m_tdata[19:9]), int'(want_word.wgt));
                if ($signed(m_tdata[33:20]) != want_word.dr)
                    flag_error("dna_rna_energy", int'($signed(m_tdata[33:20])),
                               int'(want_word.dr));
                if ($signed(m_tdata[47:34]) != want_word.rr)
                    flag_error("rna_rna_energy", int'($signed(m_tdata[47:34])),
                               int'(want_word.rr));
                if (m_tlast != want_word.last)
                    flag_error("last_of_probe", int'(m_tlast), int'(want_word.last));
            end
        end
    end

    // result sink: short random stalls, one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
                hold_sink = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_probe(input logic [49:0] bases, input logic col,
                              input logic par, input logic ann);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, bases};
        s_tuser  <= {ann, par, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(input logic signed [10:0] dr, input logic signed [10:0] rr,
                              input logic signed [8:0] pen);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DNA_START;
        cfg_wdata <= dr;
        @(posedge aclk);
        cfg_index <= CFG_RNA_START;
        cfg_wdata <= rr;
        @(posedge aclk);
        cfg_index <= CFG_TERM_AT;
        cfg_wdata <= {{2{pen[8]}}, pen};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dr_start = dr;
        rr_start = rr;
        at_pen   = pen;
    endtask

    task automatic random_run(input int items);
        logic [49:0] bases;
        logic [1:0]  b;
        logic        col;
        logic        par;
        logic        ann;
        int          pick;
        int          i;
        int          j;
        for (i = 0; i < items; i++) begin
            bases = 50'({$urandom, $urandom});
            col   = 1'($urandom_range(0, 1));
            par   = 1'($urandom_range(0, 1));
            ann   = 1'b1;
            pick  = $urandom_range(0, 9);
            if (pick == 0) begin
                ann = 1'b0;
            end else if (pick <= 2) begin
                b = 2'($urandom_range(0, 3));
                bases = {PHE_PROBE_LEN{b}};
                for (j = $urandom_range(0, 3); j > 0; j--) begin
                    bases[2*$urandom_range(0, PHE_PROBE_LEN-1) +: 2] = 2'($urandom_range(0, 3));
                end
            end
            send_probe(bases, col, par, ann);
            predict_probe(bases, col, par, ann);
        end
    endtask

    initial begin
        int           n;
        probe_row_t   row;
        energy_word_t e;

        directed.push_back('{50'h0_0000_0000_0000, 1'b1, 1'b0, 1'b1, ROW_UNIFORM, 4'd0, 6650, 7415});
        directed.push_back('{50'h1_5555_5555_5555, 1'b0, 1'b1, 1'b1, ROW_UNIFORM, 4'd5, 4730, 7415});
        directed.push_back('{50'h2_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b1, ROW_UNIFORM, 4'd10, 170, 1778});
        directed.push_back('{50'h3_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, ROW_UNIFORM, 4'd15, 2090, 1778});
        directed.push_back('{50'h0_0000_0000_0000, 1'b0, 1'b0, 1'b0, ROW_BLANK, 4'd0, 0, 0});
        directed.push_back('{50'h3_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, ROW_BLANK, 4'd0, 0, 0});
        directed.push_back('{50'h0_0000_0000_0000, 1'b0, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h3_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h1_5555_5555_5555, 1'b0, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h2_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h3_1B1B_1B1B_1B1E, 1'b1, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h3_1B1B_1B1B_1B1E, 1'b0, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h1_B1E4_D278_9C36, 1'b0, 1'b1, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h0_FEDC_BA98_7654, 1'b1, 1'b1, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h2_4924_9249_2492, 1'b0, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h0_0000_0300_0000, 1'b1, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h0_0000_0300_0000, 1'b1, 1'b1, 1'b1, ROW_MODEL, 4'd0, 0, 0});
        directed.push_back('{50'h3_FFFF_FCFF_FFFF, 1'b0, 1'b0, 1'b1, ROW_MODEL, 4'd0, 0, 0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            row = directed[i];
            send_probe(row.bases, row.col, row.par, row.ann);
            if (row.kind == ROW_MODEL) begin
                predict_probe(row.bases, row.col, row.par, row.ann);
            end else begin
                for (n = 0; n < PHE_CLASSES; n++) begin
                    e.cls  = 4'(n);
                    e.cnt  = (row.kind == ROW_UNIFORM && n == row.cls) ? 5'd24 : 5'd0;
                    e.wgt  = (row.kind == ROW_UNIFORM && n == row.cls) ? 11'd1144 : 11'd0;
                    e.dr   = 14'(row.dr);
                    e.rr   = 14'(row.rr);
                    e.last = (n == PHE_CLASSES - 1);
                    pending_words.push_back(e);
                end
            end
        end
        random_run(RANDOM_RUN);
        drain();

        set_config(-11'sd1000, -11'sd1000, -9'sd200);
        hold_sink = 1'b1;
        random_run(RANDOM_RUN);
        drain();

        set_config(11'sd0, 11'sd0, 9'sd0);
        random_run(RANDOM_RUN);
        drain();

        // no random stalls on either side; intake still waits for s_tready
        set_config(11'(-int'($urandom_range(0, 1000))),
                   11'(-int'($urandom_range(0, 1000))),
                   9'(-int'($urandom_range(0, 200))));
        idle_on = 1'b0;
        random_run(RANDOM_RUN);
        drain();

        if (error_count == 0) begin
            $display("probe_hybridization_energy verification clean");
        end else begin
            $display("probe_hybridization_energy verification failed");
        end
        $finish;
    end
endmodule

// File: sim.f
design/phe_pkg.sv
design/phe_front.sv
design/phe_fifo.sv
design/phe_accum.sv
design/phe_emit.sv
design/probe_hybridization_energy.sv
bench/tb.sv
